>>> rtl/touch_gesture_event_filter_unit_macros.svh
// Assertion macros shared by the touch gesture event filter RTL.
`ifndef TOUCH_GESTURE_EVENT_FILTER_UNIT_MACROS_SVH
`define TOUCH_GESTURE_EVENT_FILTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Immediate implication, checked on every rising clock edge outside reset.
`define TGEF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next clock cycle.
`define TGEF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TGEF_ASSERT_IMPL(lbl, ante, cons, msg)
`define TGEF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/tgef_pkg.sv
// Package for the touch gesture event filter: types, constants and decode functions.
`default_nettype none

package tgef_pkg;

	localparam int unsigned GBITS_W  = 13;
	localparam int unsigned INFO_W   = 16;
	localparam int unsigned ELAPSED_W = 16;
	localparam int unsigned CFG_W    = 16;

	// Reset values of the configuration registers
	localparam logic [ELAPSED_W-1:0] DUP_WINDOW_RESET   = 16'd120;
	localparam logic [GBITS_W-1:0]   LATCHED_MASK_RESET = 13'h1E18;

	// Info word flags
	localparam int unsigned INFO_ATI_ERR_BIT = 3;
	localparam int unsigned INFO_REATI_BIT   = 4;
	localparam int unsigned INFO_RESET_BIT   = 7;

	// Gesture bit groups
	localparam logic [GBITS_W-1:0] TAPHOLD_GROUP = 13'h000F;
	localparam logic [GBITS_W-1:0] SWIPE_GROUP   = 13'h01E0;
	localparam int unsigned        SWIPE_LSB     = 5;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_DUP_WINDOW   = 1'b0,
		CFG_LATCHED_MASK = 1'b1
	} cfg_index_t;

	// Item kinds on the input stream
	typedef enum logic [0:0] {
		KIND_FRAME = 1'b0,
		KIND_TICK  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		FS_NORMAL    = 2'd0,
		FS_CHIP_RST  = 2'd1,
		FS_ATI_ERR   = 2'd2,
		FS_REATI     = 2'd3
	} frame_status_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_SINGLE = 3'd1,
		EV_DOUBLE = 3'd2,
		EV_TRIPLE = 3'd3,
		EV_HOLD   = 3'd4
	} discrete_event_t;

	// One result item
	typedef struct packed {
		frame_status_t       frame_status;
		discrete_event_t     discrete_event;
		logic                swipe_valid;
		logic [1:0]          swipe_dir;
		logic [GBITS_W-1:0]  extra_bits;
		logic                sleep_request;
		logic                reboot_request;
	} result_t;

	// Status of a frame from its info word; reset outranks ATI error, then re-ATI.
	function automatic frame_status_t frame_status_of(input logic [INFO_W-1:0] info);
		frame_status_t st;
		st = FS_NORMAL;
		if (info[INFO_RESET_BIT]) begin
			st = FS_CHIP_RST;
		end else if (info[INFO_ATI_ERR_BIT]) begin
			st = FS_ATI_ERR;
		end else if (info[INFO_REATI_BIT]) begin
			st = FS_REATI;
		end
		return st;
	endfunction

	// Prioritised tap/hold event: triple, double, single, then hold.
	function automatic discrete_event_t tap_event(input logic [GBITS_W-1:0] g);
		discrete_event_t ev;
		ev = EV_NONE;
		if (g[2]) begin
			ev = EV_TRIPLE;
		end else if (g[1]) begin
			ev = EV_DOUBLE;
		end else if (g[0]) begin
			ev = EV_SINGLE;
		end else if (g[3]) begin
			ev = EV_HOLD;
		end
		return ev;
	endfunction

endpackage

`default_nettype wire

>>> rtl/touch_gesture_event_filter_unit.sv
// Touch gesture event filter: status screening, edge and duplicate filtering, gesture decode.
//
//  Channel    Direction  Payload
//  s_axis     in         tuser[0] kind; tdata[12:0] gesture_bits, [28:13] chip_info
//  m_axis     out        tuser[1:0] frame_status; tdata event, swipe, extra bits, requests
//  cfg        in         cfg_index 0 dup_window_ms, 1 latched_mask; cfg_wdata[15:0]
//
// One item per cycle is accepted while the input register can move on. An item is
// captured in an input register and decoded against the stored gesture bits and
// elapsed counter into the output register, which offers any result. The input register
// moves on whenever the output register is empty or being taken, which is the only stall.
// Asynchronous reset restores the configuration defaults, clears the previous
// gesture bits and saturates the elapsed counter; no clearing pass is needed.
`default_nettype none

`include "touch_gesture_event_filter_unit_macros.svh"

module touch_gesture_event_filter_unit
	import tgef_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Input stream
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [31:0]         s_axis_tdata,  // [12:0] gesture_bits, [28:13] chip_info
	input  wire logic [0:0]          s_axis_tuser,  // [0] kind
	// Result stream
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [23:0]              m_axis_tdata,  // [2:0] discrete_event, [3] swipe_valid,
	                                                // [5:4] swipe_dir, [18:6] extra_bits,
	                                                // [19] sleep_request, [20] reboot_request
	output logic [1:0]               m_axis_tuser,  // [1:0] frame_status
	// Configuration writes
	input  wire logic                cfg_wr_en,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_wdata
);

	// Configuration registers
	logic [ELAPSED_W-1:0] dup_window_q;
	logic [GBITS_W-1:0]   latched_mask_q;

	// Stored filter state
	logic [GBITS_W-1:0]   prev_gbits_q;
	logic [ELAPSED_W-1:0] elapsed_q;

	// Input register
	logic                 valid_s1;
	kind_t                kind_s1;
	logic [GBITS_W-1:0]   gbits_s1;
	logic [INFO_W-1:0]    info_s1;

	// Output register
	logic                 out_valid_q;
	result_t              out_q;

	// Decode signals
	logic                 advance;
	logic                 frame_go;
	logic                 tick_go;
	frame_status_t        status;
	logic [GBITS_W-1:0]   latched;
	logic [GBITS_W-1:0]   pulse;
	logic [GBITS_W-1:0]   prev_pulse;
	logic                 dup_pulse;
	logic [GBITS_W-1:0]   fresh;
	discrete_event_t      ev;
	logic [3:0]           swipes;
	logic                 swipe_one;
	logic [1:0]           dir;
	logic [GBITS_W-1:0]   rest;
	result_t              res;
	logic                 res_valid;

	// The input stage moves on whenever the output register can take a result.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign frame_go      = valid_s1 && advance && (kind_s1 == KIND_FRAME);
	assign tick_go       = valid_s1 && advance && (kind_s1 == KIND_TICK);

	// Frame decode against the stored state.
	always_comb begin
		status     = frame_status_of(info_s1);
		latched    = gbits_s1 & latched_mask_q;
		pulse      = gbits_s1 & ~latched_mask_q;
		prev_pulse = prev_gbits_q & ~latched_mask_q;
		dup_pulse  = (pulse != '0) && (pulse == prev_pulse) && (elapsed_q < dup_window_q);
		fresh      = (latched & ~prev_gbits_q) | (dup_pulse ? '0 : pulse);

		ev         = tap_event(fresh & TAPHOLD_GROUP);
		swipes     = fresh[SWIPE_LSB +: 4];
		swipe_one  = $onehot(swipes);
		dir        = 2'd0;
		if (swipe_one) begin
			for (int i = 0; i < 4; i++) begin
				if (swipes[i]) begin
					dir = 2'(i);
				end
			end
		end
		rest       = fresh & ~(TAPHOLD_GROUP | SWIPE_GROUP);

		res = '0;
		if (status != FS_NORMAL) begin
			res.frame_status = status;
		end else begin
			res.frame_status   = FS_NORMAL;
			res.discrete_event = ev;
			res.swipe_valid    = swipe_one;
			res.swipe_dir      = dir;
			res.extra_bits     = ((ev != EV_NONE) || swipe_one) ? rest : fresh;
			res.sleep_request  = (ev == EV_TRIPLE);
			res.reboot_request = (ev == EV_HOLD);
		end
		res_valid = frame_go && ((status != FS_NORMAL) || (fresh != '0));
	end

	// Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_window_q   <= DUP_WINDOW_RESET;
			latched_mask_q <= LATCHED_MASK_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_DUP_WINDOW:   dup_window_q   <= cfg_wdata;
				CFG_LATCHED_MASK: latched_mask_q <= cfg_wdata[GBITS_W-1:0];
				default:          ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1  <= kind_t'(s_axis_tuser[0]);
			gbits_s1 <= s_axis_tdata[GBITS_W-1:0];
			info_s1  <= s_axis_tdata[GBITS_W +: INFO_W];
		end
	end

	// Filter state: previous gesture bits and the saturating elapsed counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_gbits_q <= '0;
			elapsed_q    <= '1;
		end else if (tick_go) begin
			if (elapsed_q != '1) begin
				elapsed_q <= elapsed_q + 1'b1;
			end
		end else if (frame_go) begin
			if (status != FS_NORMAL) begin
				prev_gbits_q <= '0;
				elapsed_q    <= '1;
			end else begin
				prev_gbits_q <= gbits_s1;
				if (fresh != '0) begin
					elapsed_q <= '0;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	// Port packing
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.frame_status;
	assign m_axis_tdata  = {3'b000, out_q.reboot_request, out_q.sleep_request, out_q.extra_bits,
		out_q.swipe_dir, out_q.swipe_valid, out_q.discrete_event};

	// Assertions
	`TGEF_ASSERT_IMPL(a_status_payload_zero,
		out_valid_q && (out_q.frame_status != FS_NORMAL), m_axis_tdata == '0,
		"status result carries a gesture payload")
	`TGEF_ASSERT_IMPL(a_normal_not_empty,
		out_valid_q && (out_q.frame_status == FS_NORMAL),
		(out_q.discrete_event != EV_NONE) || out_q.swipe_valid || (out_q.extra_bits != '0),
		"normal result with nothing reported")
	`TGEF_ASSERT_IMPL(a_requests_match_event,
		out_valid_q,
		(out_q.sleep_request == (out_q.discrete_event == EV_TRIPLE)) &&
		(out_q.reboot_request == (out_q.discrete_event == EV_HOLD)),
		"request flags disagree with the decoded event")
	`TGEF_ASSERT_NEXT(a_status_clears_state,
		frame_go && (status != FS_NORMAL),
		(prev_gbits_q == '0) && (elapsed_q == '1),
		"status frame did not clear the filter state")
	`TGEF_ASSERT_NEXT(a_report_restarts_timer,
		res_valid && (status == FS_NORMAL), elapsed_q == '0,
		"reported frame did not restart the elapsed counter")

endmodule

`default_nettype wire

>>> verif/touch_gesture_event_filter_unit_tb.sv
// Self-checking testbench for the touch gesture event filter: directed, stall and random traffic.
module touch_gesture_event_filter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tgef_pkg::*;

	localparam int SETTLE_CYCLES    = 4;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int DRAIN_LIMIT      = 20000;
	localparam logic [INFO_W-1:0] STATUS_FLAGS = 16'h0098;

	logic clk = 1'b0;
	logic arst_n;

	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [31:0]         s_axis_tdata;   // [12:0] gesture_bits, [28:13] chip_info
	logic [0:0]          s_axis_tuser;   // [0] kind
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [23:0]         m_axis_tdata;   // [2:0] discrete_event, [3] swipe_valid, [5:4] swipe_dir,
	                                     // [18:6] extra_bits, [19] sleep_request, [20] reboot_request
	logic [1:0]          m_axis_tuser;   // [1:0] frame_status
	logic                cfg_wr_en;
	logic [0:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_wdata;

	// Predictor state and its copy of the registers
	logic [GBITS_W-1:0]   seen_bits;
	logic [ELAPSED_W-1:0] elapsed_ms;
	logic [CFG_W-1:0]     window_ms;
	logic [GBITS_W-1:0]   latched_bits_mask;

	result_t expected_reports[$];

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	bit  hold_pending   = 1'b0;
	int  mismatch_count = 0;
	int  items_sent     = 0;
	int  ticks_sent     = 0;
	int  reports_checked = 0;

	touch_gesture_event_filter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Predicts the report of one item and advances the filter state.
	function automatic bit filter_gesture_item(input kind_t k, input logic [GBITS_W-1:0] g,
			input logic [INFO_W-1:0] info, output result_t report);
		logic [GBITS_W-1:0] latched;
		logic [GBITS_W-1:0] pulse;
		logic [GBITS_W-1:0] prev_pulse;
		logic [GBITS_W-1:0] fresh;
		logic [GBITS_W-1:0] leftover;
		int swipe_count;
		report = '0;
		swipe_count = 0;
		if (k == KIND_TICK) begin
			if (elapsed_ms != '1) begin
				elapsed_ms++;
			end
			return 1'b0;
		end
		// A chip reset outranks an ATI error, which outranks a re-ATI.
		if (info[INFO_RESET_BIT]) begin
			report.frame_status = FS_CHIP_RST;
		end else if (info[INFO_ATI_ERR_BIT]) begin
			report.frame_status = FS_ATI_ERR;
		end else if (info[INFO_REATI_BIT]) begin
			report.frame_status = FS_REATI;
		end
		if (report.frame_status != FS_NORMAL) begin
			seen_bits = '0;
			elapsed_ms = '1;
			return 1'b1;
		end
		// Latched bits report on a rising edge, pulse bits unless repeated inside the window.
		latched = g & latched_bits_mask;
		pulse = g & ~latched_bits_mask;
		prev_pulse = seen_bits & ~latched_bits_mask;
		fresh = latched & ~seen_bits;
		if (pulse == '0 || pulse != prev_pulse || elapsed_ms >= window_ms) begin
			fresh |= pulse;
		end
		seen_bits = g;
		if (fresh == '0) begin
			return 1'b0;
		end
		elapsed_ms = '0;
		// Tap and hold priority: triple, double, single, then hold.
		if (fresh[2]) begin
			report.discrete_event = EV_TRIPLE;
		end else if (fresh[1]) begin
			report.discrete_event = EV_DOUBLE;
		end else if (fresh[0]) begin
			report.discrete_event = EV_SINGLE;
		end else if (fresh[3]) begin
			report.discrete_event = EV_HOLD;
		end
		for (int i = 0; i < 4; i++) begin
			if (fresh[SWIPE_LSB + i]) begin
				swipe_count++;
				report.swipe_dir = 2'(i);
			end
		end
		if (swipe_count == 1) begin
			report.swipe_valid = 1'b1;
		end else begin
			report.swipe_dir = '0;
		end
		leftover = fresh & ~(TAPHOLD_GROUP | SWIPE_GROUP);
		report.extra_bits = (report.discrete_event != EV_NONE || report.swipe_valid) ?
			leftover : fresh;
		report.sleep_request = (report.discrete_event == EV_TRIPLE);
		report.reboot_request = (report.discrete_event == EV_HOLD);
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Compare every report transaction with the oldest prediction.
	always @(posedge clk) begin : check_reports
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report: tuser %0h, tdata %0h", m_axis_tuser, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				reports_checked++;
				check_field("frame_status", want.frame_status, m_axis_tuser);
				check_field("discrete_event", want.discrete_event, m_axis_tdata[2:0]);
				check_field("swipe_valid", want.swipe_valid, m_axis_tdata[3]);
				check_field("swipe_dir", want.swipe_dir, m_axis_tdata[5:4]);
				check_field("extra_bits", want.extra_bits, m_axis_tdata[18:6]);
				check_field("sleep_request", want.sleep_request, m_axis_tdata[19]);
				check_field("reboot_request", want.reboot_request, m_axis_tdata[20]);
			end
		end
	end

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial begin : result_receiver
		int held;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				held = 0;
				while (held < LONG_HOLD_CYCLES) begin
					m_axis_tready <= 1'b0;
					@(posedge clk);
					held++;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one item, with random gaps first, and predicts it once the transaction completes.
	task automatic send_item(input kind_t k, input logic [GBITS_W-1:0] g,
			input logic [INFO_W-1:0] info);
		result_t report;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= k;
		s_axis_tdata <= {3'b000, info, g};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		items_sent++;
		if (k == KIND_TICK) begin
			ticks_sent++;
		end
		if (filter_gesture_item(k, g, info, report)) begin
			expected_reports.push_back(report);
		end
	endtask

	task automatic send_frame(input logic [GBITS_W-1:0] g, input logic [INFO_W-1:0] info);
		send_item(KIND_FRAME, g, info);
	endtask

	task automatic send_tick();
		send_item(KIND_TICK, 13'($urandom), 16'($urandom));
	endtask

	// Stops offering items until every report is in and any tick has passed through.
	task automatic drain_reports();
		s_axis_tvalid <= 1'b0;
		while (expected_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input logic [CFG_W-1:0] value);
		drain_reports();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_DUP_WINDOW) begin
			window_ms = value;
		end else begin
			latched_bits_mask = value[GBITS_W-1:0];
		end
	endtask

	// Status priority, field extremes and a tick whose payload must be ignored.
	task automatic test_status_frames();
		send_frame(13'h1FFF, 16'hFFFF);
		send_frame(13'h1FFF, 16'h0018);
		send_frame(13'h1FFF, 16'h0010);
		send_frame(13'h1FFF, 16'h0000);
		send_item(KIND_TICK, 13'h1FFF, 16'hFFFF);
	endtask

	// Each tap level, a repeated single tap inside the window and a held press.
	task automatic test_taps_and_hold();
		send_frame(13'h0007, 16'hFF67);
		send_frame(13'h0003, 16'hFF67);
		send_frame(13'h0001, 16'h0000);
		send_frame(13'h0001, 16'h0000);
		send_frame(13'h0008, 16'h0000);
		send_frame(13'h0008, 16'h0000);
	endtask

	// Single swipes, a tap hiding two swipes, and a frame with nothing new.
	task automatic test_swipes();
		send_frame(13'h0020, 16'h0000);
		send_frame(13'h0100, 16'h0000);
		send_frame(13'h1E61, 16'h0000);
		send_frame(13'h0000, 16'h0000);
	endtask

	// Duplicate window at zero and at a small value, then an all-latched mask.
	task automatic test_window_and_mask();
		write_register(CFG_DUP_WINDOW, 16'd0);
		send_frame(13'h0002, 16'h0000);
		send_frame(13'h0002, 16'h0000);
		write_register(CFG_DUP_WINDOW, 16'd2);
		send_frame(13'h0001, 16'h0000);
		send_tick();
		send_frame(13'h0001, 16'h0000);
		send_tick();
		send_frame(13'h0001, 16'h0000);
		write_register(CFG_LATCHED_MASK, 16'hFFFF);
		send_frame(13'h0001, 16'h0000);
		send_frame(13'h0001, 16'h0000);
		write_register(CFG_DUP_WINDOW, 16'hFFFF);
		write_register(CFG_LATCHED_MASK, 16'hE000 | 16'(LATCHED_MASK_RESET));
	endtask

	// The receiver holds off while items keep coming, so the input side must stall.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain_reports();
		hold_pending = 1'b1;
		for (int i = 0; i < 16; i++) begin
			send_frame(13'd1 << (i % GBITS_W), 16'($urandom) & ~STATUS_FLAGS);
		end
		drain_reports();
	endtask

	// Mostly plausible frame sequences with tick bursts; some status frames and noise.
	task automatic test_random_traffic(input int item_count, input int send_pct,
			input int recv_pct);
		int sent;
		int burst;
		int pick;
		logic [GBITS_W-1:0] bits;
		logic [INFO_W-1:0] info;
		case ($urandom_range(6))
			0: write_register(CFG_DUP_WINDOW, 16'd0);
			1: write_register(CFG_DUP_WINDOW, 16'd1);
			2: write_register(CFG_DUP_WINDOW, 16'd3);
			3: write_register(CFG_DUP_WINDOW, 16'd12);
			4: write_register(CFG_DUP_WINDOW, DUP_WINDOW_RESET);
			5: write_register(CFG_DUP_WINDOW, 16'hFFFF);
			default: write_register(CFG_DUP_WINDOW, 16'($urandom));
		endcase
		case ($urandom_range(3))
			0: write_register(CFG_LATCHED_MASK, 16'h0000);
			1: write_register(CFG_LATCHED_MASK, 16'h1FFF);
			2: write_register(CFG_LATCHED_MASK, 16'(LATCHED_MASK_RESET));
			default: write_register(CFG_LATCHED_MASK, 16'($urandom));
		endcase
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < item_count) begin
			pick = $urandom_range(99);
			info = 16'($urandom) & ~STATUS_FLAGS;
			if (pick < 22) begin
				burst = $urandom_range(1, 10);
				repeat (burst) send_tick();
				sent += burst;
			end else begin
				if (pick < 30) begin
					info = 16'($urandom);
					case ($urandom_range(2))
						0: info[INFO_RESET_BIT] = 1'b1;
						1: info[INFO_ATI_ERR_BIT] = 1'b1;
						default: info[INFO_REATI_BIT] = 1'b1;
					endcase
				end
				if (pick < 55) begin
					// Repeat the last frame, sometimes with one bit changed.
					bits = seen_bits;
					if ($urandom_range(1) != 0) begin
						bits[$urandom_range(GBITS_W - 1)] ^= 1'b1;
					end
				end else if (pick < 78) begin
					bits = (seen_bits & latched_bits_mask) | (13'd1 << $urandom_range(GBITS_W - 1));
				end else begin
					bits = 13'($urandom);
				end
				send_frame(bits, info);
				sent++;
			end
		end
	endtask

	// Test sequence.
	initial begin : run_tests
		int waited;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		window_ms = DUP_WINDOW_RESET;
		latched_bits_mask = LATCHED_MASK_RESET;
		seen_bits = '0;
		elapsed_ms = '1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_status_frames();
		test_taps_and_hold();
		test_swipes();
		test_window_and_mask();
		test_backpressure();
		test_random_traffic(175, 0, 0);
		test_random_traffic(175, 70, 0);
		test_random_traffic(175, 0, 70);
		test_random_traffic(175, 33, 33);

		// Let the last reports out, then allow for the pipeline depth.
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (expected_reports.size() != 0) begin
			$error("%0d predicted reports never arrived", expected_reports.size());
			mismatch_count++;
		end
		$display("Sent %0d items (%0d ticks) and checked %0d reports.",
			items_sent, ticks_sent, reports_checked);
		$display("Covered status priority, taps, swipes, window and mask extremes, a long stall.");
		if (mismatch_count == 0) begin
			$display("touch_gesture_event_filter_unit_tb: done, clean");
		end else begin
			$display("touch_gesture_event_filter_unit_tb: done, errors");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#2ms;
		$display("touch_gesture_event_filter_unit_tb: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tgef_pkg.sv
rtl/touch_gesture_event_filter_unit.sv
verif/touch_gesture_event_filter_unit_tb.sv
